/* rtl/chpc_pkg.sv */
// ----------------------------------------------------------------------------
// chpc_pkg
// Shared sizes and types of the convex hull containment block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chpc_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 24;
   localparam int TOL_BITS   = 21;
   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int HULL_DEPTH = 2 * MAX_POINTS + 1;
   localparam int HIDX_BITS  = $clog2(HULL_DEPTH + 1);
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int VERT_BITS  = 7;
   localparam int PT_BITS    = 2 * COORD_BITS;

   localparam logic [VERT_BITS-1:0] VERT_MAX = {VERT_BITS{1'b1}};

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [1:0] {
      PH_LOW = 2'd0,
      PH_UP  = 2'd1,
      PH_TST = 2'd2
   } phase_type;

endpackage

/* rtl/convex_hull_point_containment.sv */
// ----------------------------------------------------------------------------
// convex_hull_point_containment
// Collects support points, builds a monotone chain hull on a query and
// tests whether the query point lies inside or on it.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | tdata: point_x, point_y ; tuser: operation
//  rsp     | out | tdata: inside_res, hull_vertices, overflowed
//  csr     | in  | data: cross_tolerance
//
//  An added point is stored on its handshake. A query sorts the points by
//  insertion, dropping duplicates, then builds the chain and runs the side
//  test; every cross product runs through one shared 25x25 multiplier.
//  Reset clears the point count, the overflow flag and sets the tolerance
//  to 7. A query waits while a result is still held in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module convex_hull_point_containment (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [47:0]                   req_tdata,  // point_x, point_y
   input  logic                          req_tuser,  // operation
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // inside_res, hull_vertices, overflowed
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [chpc_pkg::TOL_BITS-1:0] csr_data
);

   localparam int C  = chpc_pkg::COORD_BITS;
   localparam int IB = chpc_pkg::IDX_BITS;
   localparam int CB = chpc_pkg::CNT_BITS;
   localparam int HB = chpc_pkg::HIDX_BITS;
   localparam int PB = chpc_pkg::PT_BITS;

   typedef enum logic [24:0] {
      S_IDLE   = 25'd1 << 0,
      S_SRD    = 25'd1 << 1,
      S_SLD    = 25'd1 << 2,
      S_SCHK   = 25'd1 << 3,
      S_SCMP   = 25'd1 << 4,
      S_SINS   = 25'd1 << 5,
      S_BLD    = 25'd1 << 6,
      S_LNEXT  = 25'd1 << 7,
      S_LPUSH  = 25'd1 << 8,
      S_UNEXT  = 25'd1 << 9,
      S_UPUSH  = 25'd1 << 10,
      S_TSTART = 25'd1 << 11,
      S_TNEXT  = 25'd1 << 12,
      S_XHA    = 25'd1 << 13,
      S_XHB    = 25'd1 << 14,
      S_XSO    = 25'd1 << 15,
      S_XSA    = 25'd1 << 16,
      S_XSC    = 25'd1 << 17,
      S_XCL    = 25'd1 << 18,
      S_M1     = 25'd1 << 19,
      S_M2     = 25'd1 << 20,
      S_M3     = 25'd1 << 21,
      S_CMP    = 25'd1 << 22,
      S_DRD    = 25'd1 << 23,
      S_DWR    = 25'd1 << 24
   } state_type;

   state_type state_ff, state_in;
   chpc_pkg::phase_type phase_ff, phase_in;

   logic [chpc_pkg::TOL_BITS-1:0] tol_ff, tol_in;
   logic [CB-1:0] cnt_ff, cnt_in, i_ff, i_in, n_ff, n_in, j_ff, j_in;
   logic          ovf_ff, ovf_in;
   logic [HB-1:0] m_ff, m_in, lower_ff, lower_in, t_ff, t_in;
   logic [HB-1:0] ha_ff, ha_in, hb_ff, hb_in;
   logic [CB-1:0] ci_ff, ci_in;
   logic          useq_ff, useq_in, pos_ff, pos_in, neg_ff, neg_in, inside_ff, inside_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;

   logic [PB-1:0] pt_mem [chpc_pkg::MAX_POINTS];
   logic [PB-1:0] sort_mem [chpc_pkg::MAX_POINTS];
   logic [IB-1:0] hull_mem [chpc_pkg::HULL_DEPTH];
   logic [PB-1:0] pt_q, sort_q;
   logic [IB-1:0] hull_q;
   logic [IB-1:0] pt_raddr, sort_raddr, sort_waddr;
   logic [HB-1:0] hull_raddr, hull_waddr;
   logic          pt_we, sort_we, hull_we;
   logic [PB-1:0] sort_wdata;
   logic [IB-1:0] hull_wdata;

   chpc_pkg::coord_type qx_ff, qy_ff, cx_ff, cy_ff, ox_ff, oy_ff, ax_ff, ay_ff;
   chpc_pkg::coord_type kx_ff, ky_ff;
   logic [IB-1:0] aidx_ff, bidx_ff;
   logic signed [chpc_pkg::DIFF_BITS-1:0]  mul_a, mul_b;
   logic signed [chpc_pkg::PROD_BITS-1:0]  prod_ff, keep_ff;
   logic signed [chpc_pkg::CROSS_BITS-1:0] cross_ff, tol_s;
   logic gt, lt, req_hs, sx_gt, sx_eq, sy_ge, sy_eq;
   chpc_pkg::coord_type sx, sy;

   assign req_hs     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !(req_tuser && rsp_valid_ff);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign tol_s = chpc_pkg::CROSS_BITS'(tol_ff);
   assign gt    = cross_ff > tol_s;
   assign lt    = cross_ff < -tol_s;

   assign sx    = sort_q[C-1:0];
   assign sy    = sort_q[PB-1:C];
   assign sx_gt = sx > kx_ff;
   assign sx_eq = sx == kx_ff;
   assign sy_ge = sy >= ky_ff;
   assign sy_eq = sy == ky_ff;

   assign pt_we    = req_hs && !req_tuser && (cnt_ff < CB'(chpc_pkg::MAX_POINTS));
   assign pt_raddr = i_ff[IB-1:0];

   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[cnt_ff[IB-1:0]] <= req_tdata[PB-1:0];
      pt_q <= pt_mem[pt_raddr];
      if (sort_we) sort_mem[sort_waddr] <= sort_wdata;
      sort_q <= sort_mem[sort_raddr];
      if (hull_we) hull_mem[hull_waddr] <= hull_wdata;
      hull_q <= hull_mem[hull_raddr];
   end

   always_comb begin
      mul_a = chpc_pkg::DIFF_BITS'(ax_ff) - chpc_pkg::DIFF_BITS'(ox_ff);
      mul_b = chpc_pkg::DIFF_BITS'(cy_ff) - chpc_pkg::DIFF_BITS'(oy_ff);
      if (state_ff == S_M2) begin
         mul_a = chpc_pkg::DIFF_BITS'(ay_ff) - chpc_pkg::DIFF_BITS'(oy_ff);
         mul_b = chpc_pkg::DIFF_BITS'(cx_ff) - chpc_pkg::DIFF_BITS'(ox_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (req_hs) begin
         qx_ff <= req_tdata[C-1:0];
         qy_ff <= req_tdata[PB-1:C];
      end
      if (state_ff == S_SLD) begin
         kx_ff <= pt_q[C-1:0];
         ky_ff <= pt_q[PB-1:C];
      end
      if (state_ff == S_XHB) aidx_ff <= hull_q;
      if (state_ff == S_XSO) bidx_ff <= hull_q;
      if (state_ff == S_XSA) begin
         ox_ff <= sort_q[C-1:0];
         oy_ff <= sort_q[PB-1:C];
      end
      if (state_ff == S_XSC) begin
         ax_ff <= sort_q[C-1:0];
         ay_ff <= sort_q[PB-1:C];
      end
      if (state_ff == S_XCL) begin
         cx_ff <= useq_ff ? qx_ff : sort_q[C-1:0];
         cy_ff <= useq_ff ? qy_ff : sort_q[PB-1:C];
      end
      if (state_ff == S_M1 || state_ff == S_M2) prod_ff <= mul_a * mul_b;
      if (state_ff == S_M2) keep_ff <= prod_ff;
      if (state_ff == S_M3) begin
         cross_ff <= chpc_pkg::CROSS_BITS'(keep_ff) - chpc_pkg::CROSS_BITS'(prod_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      tol_in       = tol_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      m_in         = m_ff;
      lower_in     = lower_ff;
      t_in         = t_ff;
      ha_in        = ha_ff;
      hb_in        = hb_ff;
      ci_in        = ci_ff;
      useq_in      = useq_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      inside_in    = inside_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      sort_raddr   = '0;
      sort_we      = 1'b0;
      sort_waddr   = j_ff[IB-1:0];
      sort_wdata   = {ky_ff, kx_ff};
      hull_raddr   = ha_ff;
      hull_we      = 1'b0;
      hull_waddr   = m_ff;
      hull_wdata   = i_ff[IB-1:0];

      if (csr_valid) tol_in = csr_data;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_hs) begin
               if (!req_tuser) begin
                  if (pt_we) cnt_in = cnt_ff + 1'b1;
                  else ovf_in = 1'b1;
               end else begin
                  i_in     = '0;
                  n_in     = '0;
                  state_in = (cnt_ff == '0) ? S_BLD : S_SRD;
               end
            end
         end
         S_SRD: state_in = S_SLD;
         S_SLD: begin
            j_in     = n_ff;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            sort_raddr = IB'(j_ff - 1'b1);
            state_in   = (j_ff == '0) ? S_SINS : S_SCMP;
         end
         S_SCMP: begin
            if (sx_gt || (sx_eq && sy_ge)) begin
               if (sx_eq && sy_eq) begin
                  if (j_ff == n_ff) begin
                     i_in     = i_ff + 1'b1;
                     state_in = (i_ff + 1'b1 == cnt_ff) ? S_BLD : S_SRD;
                  end else begin
                     state_in = S_DRD;
                  end
               end else begin
                  sort_we    = 1'b1;
                  sort_wdata = sort_q;
                  j_in       = j_ff - 1'b1;
                  state_in   = S_SCHK;
               end
            end else begin
               state_in = S_SINS;
            end
         end
         S_DRD: begin
            sort_raddr = IB'(j_ff + 1'b1);
            state_in   = S_DWR;
         end
         S_DWR: begin
            sort_we    = 1'b1;
            sort_wdata = sort_q;
            j_in       = j_ff + 1'b1;
            if (j_ff + 1'b1 == n_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = (i_ff + 1'b1 == cnt_ff) ? S_BLD : S_SRD;
            end else begin
               state_in = S_DRD;
            end
         end
         S_SINS: begin
            sort_we  = 1'b1;
            n_in     = n_ff + 1'b1;
            i_in     = i_ff + 1'b1;
            state_in = (i_ff + 1'b1 == cnt_ff) ? S_BLD : S_SRD;
         end
         S_BLD: begin
            if (n_ff <= CB'(2)) begin
               m_in      = HB'(n_ff);
               inside_in = 1'b0;
               state_in  = S_TSTART;
            end else begin
               i_in     = '0;
               m_in     = '0;
               state_in = S_LNEXT;
            end
         end
         S_LNEXT: begin
            if (m_ff >= HB'(2)) begin
               ha_in    = m_ff - HB'(2);
               hb_in    = m_ff - HB'(1);
               ci_in    = i_ff;
               useq_in  = 1'b0;
               phase_in = chpc_pkg::PH_LOW;
               state_in = S_XHA;
            end else begin
               state_in = S_LPUSH;
            end
         end
         S_LPUSH: begin
            hull_we = 1'b1;
            m_in    = m_ff + 1'b1;
            if (i_ff + 1'b1 == n_ff) begin
               lower_in = m_ff + 1'b1;
               i_in     = n_ff - CB'(2);
               state_in = S_UNEXT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_LNEXT;
            end
         end
         S_UNEXT: begin
            if (m_ff > lower_ff) begin
               ha_in    = m_ff - HB'(2);
               hb_in    = m_ff - HB'(1);
               ci_in    = i_ff;
               useq_in  = 1'b0;
               phase_in = chpc_pkg::PH_UP;
               state_in = S_XHA;
            end else begin
               state_in = S_UPUSH;
            end
         end
         S_UPUSH: begin
            if (m_ff < HB'(chpc_pkg::HULL_DEPTH)) begin
               hull_we = 1'b1;
               m_in    = m_ff + 1'b1;
            end
            if (i_ff == '0) begin
               m_in     = (m_ff < HB'(chpc_pkg::HULL_DEPTH)) ? m_ff : m_ff - 1'b1;
               state_in = S_TSTART;
            end else begin
               i_in     = i_ff - 1'b1;
               state_in = S_UNEXT;
            end
         end
         S_TSTART: begin
            if (m_ff >= HB'(3)) begin
               t_in     = '0;
               pos_in   = 1'b0;
               neg_in   = 1'b0;
               state_in = S_TNEXT;
            end else begin
               inside_in    = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, ovf_ff,
                               (m_ff > HB'(chpc_pkg::VERT_MAX)) ? chpc_pkg::VERT_MAX
                                                                : m_ff[6:0], 1'b0};
               cnt_in       = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_TNEXT: begin
            ha_in    = t_ff;
            hb_in    = (t_ff + 1'b1 == m_ff) ? '0 : t_ff + 1'b1;
            useq_in  = 1'b1;
            phase_in = chpc_pkg::PH_TST;
            state_in = S_XHA;
         end
         S_XHA: begin
            hull_raddr = ha_ff;
            state_in   = S_XHB;
         end
         S_XHB: begin
            hull_raddr = hb_ff;
            state_in   = S_XSO;
         end
         S_XSO: begin
            sort_raddr = aidx_ff;
            state_in   = S_XSA;
         end
         S_XSA: begin
            sort_raddr = bidx_ff;
            state_in   = S_XSC;
         end
         S_XSC: begin
            sort_raddr = ci_ff[IB-1:0];
            state_in   = S_XCL;
         end
         S_XCL: state_in = S_M1;
         S_M1:  state_in = S_M2;
         S_M2:  state_in = S_M3;
         S_M3:  state_in = S_CMP;
         S_CMP: begin
            case (phase_ff)
               chpc_pkg::PH_LOW: begin
                  if (gt) state_in = S_LPUSH;
                  else begin
                     m_in     = m_ff - 1'b1;
                     state_in = S_LNEXT;
                  end
               end
               chpc_pkg::PH_UP: begin
                  if (gt) state_in = S_UPUSH;
                  else begin
                     m_in     = m_ff - 1'b1;
                     state_in = S_UNEXT;
                  end
               end
               default: begin
                  pos_in = pos_ff || gt;
                  neg_in = neg_ff || lt;
                  t_in   = t_ff + 1'b1;
                  if ((pos_ff || gt) && (neg_ff || lt)) begin
                     inside_in = 1'b0;
                     state_in  = S_TSTART;
                     m_in      = m_ff;
                  end else if (t_ff + 1'b1 == m_ff) begin
                     inside_in = 1'b1;
                     state_in  = S_TSTART;
                  end else begin
                     state_in = S_TNEXT;
                  end
               end
            endcase
            if (phase_ff == chpc_pkg::PH_TST && state_in == S_TSTART) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, ovf_ff,
                               (m_ff > HB'(chpc_pkg::VERT_MAX)) ? chpc_pkg::VERT_MAX
                                                                : m_ff[6:0], inside_in};
               cnt_in       = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= chpc_pkg::TOL_BITS'(7);
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      i_ff        <= i_in;
      n_ff        <= n_in;
      j_ff        <= j_in;
      m_ff        <= m_in;
      lower_ff    <= lower_in;
      t_ff        <= t_in;
      ha_ff       <= ha_in;
      hb_ff       <= hb_in;
      ci_ff       <= ci_in;
      useq_ff     <= useq_in;
      pos_ff      <= pos_in;
      neg_ff      <= neg_in;
      inside_ff   <= inside_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Streams support point sets and query points into the hull containment
// block under several idle and stall patterns and tolerance settings, and
// checks every containment result against an in-bench hull predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class hull_scoreboard;

   chpc_pkg::coord_type pts_x[$];
   chpc_pkg::coord_type pts_y[$];
   bit                  overflow_seen;
   int unsigned         tolerance = 7;
   logic [8:0]          pending_results[$];
   int                  errors;

   static function longint cross_prod(longint ox, longint oy, longint ax, longint ay,
                                      longint bx, longint by);
      return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
   endfunction

   // {overflowed, hull_vertices, inside_res}
   function logic [8:0] predict_containment(chpc_pkg::coord_type qx, chpc_pkg::coord_type qy);
      longint xs[chpc_pkg::MAX_POINTS];
      longint ys[chpc_pkg::MAX_POINTS];
      int     hull[chpc_pkg::HULL_DEPTH + 1];
      int     n, m, j, lower, a, b;
      longint x, y, s, tol;
      bit     dup, pos, neg, in_hull;
      n = 0;
      m = 0;
      tol = tolerance;
      in_hull = 0;
      foreach (pts_x[i]) begin
         x = pts_x[i];
         y = pts_y[i];
         j = n;
         dup = 0;
         while (j > 0 && (xs[j-1] > x || (xs[j-1] == x && ys[j-1] >= y))) begin
            if (xs[j-1] == x && ys[j-1] == y) begin
               dup = 1;
               break;
            end
            j--;
         end
         if (!dup) begin
            for (int k = n; k > j; k--) begin
               xs[k] = xs[k-1];
               ys[k] = ys[k-1];
            end
            xs[j] = x;
            ys[j] = y;
            n++;
         end
      end
      if (n <= 2) begin
         for (int i = 0; i < n; i++) hull[i] = i;
         m = n;
      end else begin
         for (int i = 0; i < n; i++) begin
            while (m >= 2) begin
               a = hull[m-2];
               b = hull[m-1];
               if (cross_prod(xs[a], ys[a], xs[b], ys[b], xs[i], ys[i]) > tol) break;
               m--;
            end
            hull[m++] = i;
         end
         lower = m;
         for (int i = n - 2; i >= 0; i--) begin
            while (m > lower) begin
               a = hull[m-2];
               b = hull[m-1];
               if (cross_prod(xs[a], ys[a], xs[b], ys[b], xs[i], ys[i]) > tol) break;
               m--;
            end
            if (m < chpc_pkg::HULL_DEPTH) hull[m++] = i;
         end
         m--;
      end
      if (m >= 3) begin
         pos = 0;
         neg = 0;
         in_hull = 1;
         for (int i = 0; i < m; i++) begin
            a = hull[i];
            b = hull[(i + 1) % m];
            s = cross_prod(xs[a], ys[a], xs[b], ys[b], longint'(qx), longint'(qy));
            if (s > tol) pos = 1;
            if (s < -tol) neg = 1;
            if (pos && neg) begin
               in_hull = 0;
               break;
            end
         end
      end
      return {overflow_seen, 7'(m > 127 ? 127 : m), in_hull};
   endfunction

   function void note_request(bit op, chpc_pkg::coord_type x, chpc_pkg::coord_type y);
      if (!op) begin
         if (pts_x.size() < chpc_pkg::MAX_POINTS) begin
            pts_x.push_back(x);
            pts_y.push_back(y);
         end else begin
            overflow_seen = 1;
         end
      end else begin
         pending_results.push_back(predict_containment(x, y));
         pts_x.delete();
         pts_y.delete();
         overflow_seen = 0;
      end
   endfunction

   function void check_result(logic [15:0] data);
      logic [8:0] want;
      if (pending_results.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result %h", data);
         return;
      end
      want = pending_results.pop_front();
      if (data[0] !== want[0] || data[7:1] !== want[7:1] || data[8] !== want[8]) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: inside %0d/%0d vertices %0d/%0d overflow %0d/%0d (exp/act)",
                     want[0], data[0], want[7:1], data[7:1], want[8], data[8]);
      end
   endfunction

endclass

module testbench;

   typedef chpc_pkg::coord_type coord_type;

   logic                          clock = 0;
   logic                          reset = 1;
   logic                          req_tvalid = 0;
   logic                          req_tready;
   logic [47:0]                   req_tdata = '0;
   logic                          req_tuser = 0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 0;
   logic [15:0]                   rsp_tdata;
   logic                          csr_valid = 0;
   logic                          csr_ready;
   logic [chpc_pkg::TOL_BITS-1:0] csr_data = '0;

   hull_scoreboard hull_sb = new();
   int             send_idle_pct;
   int             recv_stall_pct;
   int             hold_off_cycles;
   int             requests_sent;
   coord_type      set_x[$];
   coord_type      set_y[$];

   convex_hull_point_containment DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #60ms;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) hull_sb.check_result(rsp_tdata);
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_request(bit op, coord_type x, coord_type y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hull_sb.note_request(op, x, y);
      requests_sent++;
      if (!op) begin
         set_x.push_back(x);
         set_y.push_back(y);
      end else begin
         set_x.delete();
         set_y.delete();
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      @(posedge clock);
      while (hull_sb.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_tolerance(int unsigned value);
      csr_valid <= 1;
      csr_data  <= chpc_pkg::TOL_BITS'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      hull_sb.tolerance = value;
   endtask

   function automatic coord_type pick_coord(int style, int base);
      case (style)
         0: return coord_type'(base + $urandom_range(0, 400) - 200);
         1: return coord_type'($urandom);
         2: return $urandom_range(1) ? coord_type'(24'h7fffff) : coord_type'(24'h800000);
         default: return coord_type'(base + $urandom_range(0, 8) - 4);
      endcase
   endfunction

   // Send one point set and its query.
   task automatic send_set(int count, int style);
      int        slope, offs, k, pick;
      coord_type x, y;
      slope = $urandom_range(0, 6) - 3;
      offs  = $urandom_range(0, 20000) - 10000;
      for (int i = 0; i < count; i++) begin
         if (style == 3) begin
            x = coord_type'(offs + $urandom_range(0, 2000) - 1000);
            y = coord_type'(slope * x + pick_coord(3, 0));
         end else if (set_x.size() != 0 && $urandom_range(9) == 0) begin
            k = $urandom_range(set_x.size() - 1);
            x = set_x[k];
            y = set_y[k];
         end else begin
            x = pick_coord(style, offs);
            y = pick_coord(style, offs);
         end
         send_request(1'b0, x, y);
      end
      pick = $urandom_range(3);
      if (pick == 0 && set_x.size() != 0) begin
         k = $urandom_range(set_x.size() - 1);
         x = set_x[k];
         y = set_y[k];
      end else if (pick == 1) begin
         x = coord_type'($urandom);
         y = coord_type'($urandom);
      end else begin
         x = style == 3 ? coord_type'(offs) : pick_coord(style == 1 ? 1 : 0, offs);
         y = style == 3 ? coord_type'(slope * offs) : pick_coord(style == 1 ? 1 : 0, offs);
      end
      send_request(1'b1, x, y);
   endtask

   task automatic random_sets(int items);
      int goal, r, count;
      goal = requests_sent + items;
      while (requests_sent < goal) begin
         r = $urandom_range(99);
         count = r < 80 ? $urandom_range(0, 10) : r < 97 ? $urandom_range(11, 30)
                                                        : $urandom_range(60, 70);
         send_set(count, $urandom_range(3));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset tolerance, no idling, directed cases, then random sets
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_request(1'b1, 24'sd0, 24'sd0);
      send_request(1'b0, 24'sd10, 24'sd10);
      send_request(1'b1, 24'sd10, 24'sd10);
      send_request(1'b0, -24'sd500, 24'sd3);
      send_request(1'b0, -24'sd500, 24'sd3);
      send_request(1'b0, 24'sd700, 24'sd3);
      send_request(1'b1, 24'sd0, 24'sd3);
      send_request(1'b0, 24'sd0, 24'sd0);
      send_request(1'b0, 24'sd1000, 24'sd0);
      send_request(1'b0, 24'sd0, 24'sd1000);
      send_request(1'b0, 24'sd500, 24'sd0);
      send_request(1'b1, 24'sd200, 24'sd200);
      send_request(1'b0, 24'sd0, 24'sd0);
      send_request(1'b0, 24'sd1000, 24'sd0);
      send_request(1'b0, 24'sd0, 24'sd1000);
      send_request(1'b1, 24'sd500, 24'sd500);
      send_request(1'b0, 24'sh800000, 24'sh800000);
      send_request(1'b0, 24'sh7fffff, 24'sh800000);
      send_request(1'b0, 24'sh7fffff, 24'sh7fffff);
      send_request(1'b0, 24'sh800000, 24'sh7fffff);
      send_request(1'b1, 24'sh7fffff, 24'sd0);
      send_request(1'b0, 24'sd0, 24'sd0);
      send_request(1'b0, 24'sd100, 24'sd1);
      send_request(1'b0, 24'sd200, 24'sd0);
      send_request(1'b1, 24'sd1000, 24'sd0);
      random_sets(80);
      wait_drained();

      write_tolerance(0);
      send_idle_pct = 83;
      random_sets(110);
      wait_drained();

      write_tolerance(1048576);
      send_idle_pct  = 0;
      recv_stall_pct = 83;
      send_set(65, 0);
      hold_off_cycles = 3000;
      for (int i = 0; i < 6; i++) send_set(3, 0);
      random_sets(110);
      wait_drained();

      write_tolerance($urandom_range(1, 5000));
      send_idle_pct  = 36;
      recv_stall_pct = 36;
      random_sets(110);
      wait_drained();

      write_tolerance(7);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_sets(80);
      wait_drained();

      hull_sb.errors += hull_sb.pending_results.size();
      if (hull_sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
rtl/chpc_pkg.sv
rtl/convex_hull_point_containment.sv
tb/testbench.sv
